// ----- sv/spag_pkg.sv -----
// Package for the sliding piece attack generator: board masks and line helpers.
package spag_pkg;

    // Board geometry
    localparam int unsigned SQ_W    = 6;
    localparam int unsigned BOARD_W = 64;

    // Stream payload widths (tdata padded to whole bytes)
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 64;

    // Direction selector carried on tuser
    localparam logic FUNC_STRAIGHT = 1'b0;
    localparam logic FUNC_DIAGONAL = 1'b1;

    // Base line patterns
    localparam logic [BOARD_W-1:0] FILE_A_MASK    = 64'h0101_0101_0101_0101;
    localparam logic [BOARD_W-1:0] RANK_1_MASK    = 64'h0000_0000_0000_00FF;
    localparam logic [BOARD_W-1:0] MAIN_DIAG_MASK = 64'h8040_2010_0804_0201;
    localparam logic [BOARD_W-1:0] ANTI_DIAG_MASK = 64'h0102_0408_1020_4080;

    typedef logic [BOARD_W-1:0] t_board;

    typedef struct packed {
        t_board m1;
        t_board m2;
    } t_line_masks;

    // Mirror a board word: bit i moves to bit 63 - i (pure wiring)
    function automatic t_board f_bit_reverse(input t_board w);
        t_board r;
        for (int i = 0; i < BOARD_W; i++) begin
            r[i] = w[BOARD_W-1-i];
        end
        return r;
    endfunction

    // Build the two line masks of a square, the square itself removed
    function automatic t_line_masks f_line_masks(input logic func, input logic [SQ_W-1:0] sq);
        t_line_masks lm;
        t_board      piece;
        logic [2:0]  file;
        logic [2:0]  rank;
        logic [3:0]  diff;
        logic [3:0]  sum;
        logic [3:0]  neg;
        logic [3:0]  up_s;
        logic [3:0]  dn_s;
        piece = t_board'(1) << sq;
        file  = sq[2:0];
        rank  = sq[5:3];
        diff  = {1'b0, rank} - {1'b0, file};
        neg   = 4'd0 - diff;
        sum   = {1'b0, rank} + {1'b0, file};
        up_s  = sum - 4'd7;
        dn_s  = 4'd7 - sum;
        if (func == FUNC_STRAIGHT) begin
            lm.m1 = FILE_A_MASK << file;
            lm.m2 = RANK_1_MASK << {rank, 3'b000};
        end else begin
            // main diagonal moved by (rank - file) ranks
            if (!diff[3]) begin
                lm.m1 = MAIN_DIAG_MASK << {diff[2:0], 3'b000};
            end else begin
                lm.m1 = MAIN_DIAG_MASK >> {neg[2:0], 3'b000};
            end
            // anti diagonal moved by (rank + file - 7) ranks
            if (sum >= 4'd7) begin
                lm.m2 = ANTI_DIAG_MASK << {up_s[2:0], 3'b000};
            end else begin
                lm.m2 = ANTI_DIAG_MASK >> {dn_s[2:0], 3'b000};
            end
        end
        lm.m1 = lm.m1 & ~piece;
        lm.m2 = lm.m2 & ~piece;
        return lm;
    endfunction

    // Squares reached towards higher indexes along one line: o ^ (o - 2r)
    function automatic t_board f_up_attacks(input t_board piece, input t_board occ,
                                            input t_board mask);
        t_board o;
        o = occ & mask;
        return ((o - (piece << 1)) ^ o) & mask;
    endfunction

    // Both directions along one line; the lower one on mirrored words
    function automatic t_board f_line_attacks(input t_board piece, input t_board occ,
                                              input t_board mask);
        t_board fwd;
        t_board bwd;
        fwd = f_up_attacks(piece, occ, mask);
        bwd = f_bit_reverse(f_up_attacks(f_bit_reverse(piece), f_bit_reverse(occ),
                                         f_bit_reverse(mask)));
        return fwd | bwd;
    endfunction

endpackage

// ----- sv/sliding_piece_attack_generator.sv -----
// Sliding piece attack generator: registered query in, registered attack set out.
//
//  Channel | Direction | Ports                              | Item
//  query   | in        | i_s_tvalid/o_s_tready/i_s_tdata/_tuser | square, occupancy, func
//  attacks | out       | o_m_tvalid/i_m_tready/o_m_tdata    | destinations
//
//  One query per cycle unless the output stalls; o_m_tvalid rises when it enters the result stage.
//  The cycle is set by the 64-bit subtract of each line direction (four in parallel).
//  Reset (i_rst_n low at a clock edge) empties both stages; payload is not cleared.
//  A stalled output holds its item; the input stage keeps taking items while it is
//  empty or the output register is empty or being drained.
module sliding_piece_attack_generator
    import spag_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // [5:0] square, [69:6] occupancy, [71:70] zero
    input  logic                 i_s_tuser,  // [0] func
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata   // [63:0] destinations
);

    // input stage
    logic            r_s1_vld, n_s1_vld;
    logic            r_s1_func, n_s1_func;
    logic [SQ_W-1:0] r_s1_sq, n_s1_sq;
    t_board          r_s1_occ, n_s1_occ;

    // result stage
    logic            r_s2_vld, n_s2_vld;
    logic [SQ_W-1:0] r_s2_sq, n_s2_sq;
    t_board          r_s2_dst, n_s2_dst;

    logic            w_s2_load;
    logic            w_s1_load;
    t_line_masks     w_masks;
    t_board          w_piece;
    t_board          w_dst;

    // Stage handshakes
    assign w_s2_load  = !r_s2_vld || i_m_tready;
    assign o_s_tready = !r_s1_vld || w_s2_load;
    assign w_s1_load  = i_s_tvalid && o_s_tready;

    // Attack set of the query held in the input stage
    always_comb begin
        w_masks = f_line_masks(r_s1_func, r_s1_sq);
        w_piece = t_board'(1) << r_s1_sq;
        w_dst   = f_line_attacks(w_piece, r_s1_occ, w_masks.m1)
                | f_line_attacks(w_piece, r_s1_occ, w_masks.m2);
    end

    // Next state of both stages
    always_comb begin
        n_s1_vld  = r_s1_vld;
        n_s1_func = r_s1_func;
        n_s1_sq   = r_s1_sq;
        n_s1_occ  = r_s1_occ;
        n_s2_vld  = r_s2_vld;
        n_s2_sq   = r_s2_sq;
        n_s2_dst  = r_s2_dst;
        if (w_s2_load) begin
            n_s2_vld = r_s1_vld;
            n_s2_sq  = r_s1_sq;
            n_s2_dst = w_dst;
        end
        if (o_s_tready) begin
            n_s1_vld  = i_s_tvalid;
        end
        if (w_s1_load) begin
            n_s1_func = i_s_tuser;
            n_s1_sq   = i_s_tdata[SQ_W-1:0];
            n_s1_occ  = i_s_tdata[SQ_W+BOARD_W-1:SQ_W];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_s2_vld <= n_s2_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_s1_func <= n_s1_func;
        r_s1_sq   <= n_s1_sq;
        r_s1_occ  <= n_s1_occ;
        r_s2_sq   <= n_s2_sq;
        r_s2_dst  <= n_s2_dst;
    end

    assign o_m_tvalid = r_s2_vld;
    assign o_m_tdata  = r_s2_dst;

    // Own square never shows up among the destinations
    a_no_own_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> !r_s2_dst[r_s2_sq])
        else $error("attack set contains the piece square");

    // A held query is not lost while the output is stalled
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s2_vld && !i_m_tready) |=> (r_s1_vld && $stable(r_s1_occ)
            && $stable(r_s1_sq)))
        else $error("input stage dropped an item under stall");

    // An item in the input stage moves to the result stage when it is free
    a_s1_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && w_s2_load) |=> r_s2_vld)
        else $error("item did not advance to the result stage");

    // Reset leaves both stages empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_vld && !r_s2_vld))
        else $error("stages not empty after reset");

endmodule

// ----- dv/tb_sliding_piece_attack_generator.sv -----
// Testbench for the sliding piece attack generator: ray-walk predictor, stream driver and monitor.
module tb_sliding_piece_attack_generator
    import spag_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic             func;
        logic [SQ_W-1:0]  square;
        logic [BOARD_W-1:0] occupancy;
    } t_query;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;  // [5:0] square, [69:6] occupancy, [71:70] zero
    logic                 i_s_tuser  = 1'b0; // [0] func
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;          // [63:0] destinations

    t_query              query_q[$];
    logic [BOARD_W-1:0]  attack_q[$];
    int unsigned         err_count = 0;
    int unsigned         n_sent    = 0;
    int unsigned         hold_left = 0;
    logic                hold_done = 1'b0;
    logic                no_idle   = 1'b0;

    sliding_piece_attack_generator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Walk each ray from the piece, stop after the first occupied square
    function automatic logic [BOARD_W-1:0] reach_set(input logic func,
                                                     input logic [SQ_W-1:0] square,
                                                     input logic [BOARD_W-1:0] occupancy);
        logic [BOARD_W-1:0] hits;
        int df;
        int dr;
        int f;
        int r;
        hits = '0;
        for (int k = 0; k < 4; k++) begin
            if (func == FUNC_STRAIGHT) begin
                df = (k == 0) ? 1 : (k == 1) ? -1 : 0;
                dr = (k == 2) ? 1 : (k == 3) ? -1 : 0;
            end else begin
                df = (k % 2 == 1) ? -1 : 1;
                dr = (k >= 2) ? -1 : 1;
            end
            f = int'(square[2:0]) + df;
            r = int'(square[5:3]) + dr;
            while (f >= 0 && f < 8 && r >= 0 && r < 8) begin
                hits[r*8 + f] = 1'b1;
                if (occupancy[r*8 + f]) break;
                f = f + df;
                r = r + dr;
            end
        end
        return hits;
    endfunction

    task automatic report_mismatch(input string what, input logic [BOARD_W-1:0] got,
                                   input logic [BOARD_W-1:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        err_count++;
    endtask

    task automatic queue_query(input logic func, input logic [SQ_W-1:0] square,
                               input logic [BOARD_W-1:0] occupancy);
        t_query q;
        q.func      = func;
        q.square    = square;
        q.occupancy = occupancy;
        query_q.push_back(q);
    endtask

    // Mix sparse, even and dense boards; set the piece's own bit at random
    task automatic queue_random(input int count);
        logic [BOARD_W-1:0] occ;
        logic [SQ_W-1:0]    sq;
        for (int n = 0; n < count; n++) begin
            occ = {$urandom, $urandom};
            case ($urandom_range(3))
                0: occ = occ & {$urandom, $urandom} & {$urandom, $urandom};
                1: occ = occ | {$urandom, $urandom};
                2: occ = occ & {$urandom, $urandom};
                default: ;
            endcase
            sq = SQ_W'($urandom_range(63));
            occ[sq] = 1'($urandom_range(1));
            queue_query($urandom_range(1) ? FUNC_DIAGONAL : FUNC_STRAIGHT, sq, occ);
        end
    endtask

    task automatic wait_drained();
        while (query_q.size() != 0 || attack_q.size() != 0) @(negedge i_clk);
    endtask

    // Drive queries; hold the item while it is stalled
    always @(posedge i_clk) begin
        logic take;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            take = i_s_tvalid && o_s_tready;
            if (take) begin
                attack_q.push_back(reach_set(i_s_tuser, i_s_tdata[5:0], i_s_tdata[69:6]));
                void'(query_q.pop_front());
                n_sent <= n_sent + 1;
            end
            if (!i_s_tvalid || take) begin
                if (query_q.size() != 0 && (no_idle || $urandom_range(99) >= 6)) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {2'b00, query_q[0].occupancy, query_q[0].square};
                    i_s_tuser  <= query_q[0].func;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Hold off the receiver once for a long stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_sent >= 60) begin
            hold_left <= 48;
            hold_done <= 1'b1;
        end
    end

    // Check each attack set against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (attack_q.size() == 0) begin
                    report_mismatch("unexpected item", o_m_tdata, '0);
                end else if (o_m_tdata !== attack_q[0]) begin
                    report_mismatch("destinations", o_m_tdata, attack_q.pop_front());
                end else begin
                    void'(attack_q.pop_front());
                end
            end
            i_m_tready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= 6);
        end
    end

    // Stimulus phases
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Corners, edges, empty and full boards, own square occupied or not
        queue_query(FUNC_STRAIGHT, 6'd0,  '0);
        queue_query(FUNC_DIAGONAL, 6'd0,  '0);
        queue_query(FUNC_STRAIGHT, 6'd63, '1);
        queue_query(FUNC_DIAGONAL, 6'd63, '1);
        queue_query(FUNC_STRAIGHT, 6'd63, '0);
        queue_query(FUNC_DIAGONAL, 6'd63, '0);
        queue_query(FUNC_STRAIGHT, 6'd7,  '0);
        queue_query(FUNC_DIAGONAL, 6'd7,  '0);
        queue_query(FUNC_STRAIGHT, 6'd56, '0);
        queue_query(FUNC_DIAGONAL, 6'd56, '1);
        queue_query(FUNC_STRAIGHT, 6'd27, 64'h0000_0000_0800_0000);
        queue_query(FUNC_STRAIGHT, 6'd27, '0);
        queue_query(FUNC_DIAGONAL, 6'd36, 64'h0000_0010_0000_0000);
        queue_query(FUNC_DIAGONAL, 6'd36, ~64'h0000_0010_0000_0000);
        queue_query(FUNC_STRAIGHT, 6'd36, '1);
        // Next rank's first square must not block a piece on the last file
        queue_query(FUNC_STRAIGHT, 6'd15, 64'h0000_0000_0001_0000);
        queue_query(FUNC_DIAGONAL, 6'd15, 64'h0000_0000_0001_0000);
        queue_query(FUNC_STRAIGHT, 6'd8,  64'h0000_0000_0000_0080);
        queue_query(FUNC_DIAGONAL, 6'd35, 64'h8100_0000_0000_0081);
        queue_query(FUNC_STRAIGHT, 6'd28, 64'h1000_0000_0000_0010);
        queue_query(FUNC_DIAGONAL, 6'd62, {$urandom, $urandom});
        queue_query(FUNC_STRAIGHT, 6'd1,  {$urandom, $urandom});
        wait_drained();

        // Random boards; receiver hold-off falls in here
        queue_random(150);
        wait_drained();

        // Back-to-back with no idling on either side
        no_idle = 1'b1;
        queue_random(100);
        wait_drained();
        no_idle = 1'b0;

        queue_random(200);
        wait_drained();
        repeat (10) @(negedge i_clk);

        if (err_count == 0) begin
            $display("sliding_piece_attack_generator test passed");
        end else begin
            $display("sliding_piece_attack_generator test failed");
        end
        $finish;
    end

    // Give up after a generous time
    initial begin
        #2_000_000;
        $display("sliding_piece_attack_generator test failed");
        $finish;
    end

endmodule
